>>> rtl/uer_pkg.sv
package uer_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int DIST_W     = 27;
    localparam int STATUS_W   = 2;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_TICKS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_UNIT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_COUNT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MM_PER_TWO_UNITS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_MM           = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MM           = 3'd5;

    localparam logic [15:0] RST_TRIGGER_TICKS    = 16'd50;
    localparam logic [7:0]  RST_TICKS_PER_UNIT   = 8'd9;
    localparam logic [23:0] RST_TIMEOUT_COUNT    = 24'd10000000;
    localparam logic [3:0]  RST_MM_PER_TWO_UNITS = 4'd3;
    localparam logic [15:0] RST_MIN_MM           = 16'd20;
    localparam logic [15:0] RST_MAX_MM           = 16'd4000;

    localparam logic [STATUS_W-1:0] ST_VALID   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TIMEOUT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd2;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    typedef struct packed {
        logic [15:0] trigger_ticks;
        logic [7:0]  ticks_per_unit;
        logic [23:0] timeout_count;
        logic [3:0]  mm_per_two_units;
        logic [15:0] min_mm;
        logic [15:0] max_mm;
    } t_cfg;

    // What the sequencer decided for one tick.
    typedef struct packed {
        logic trig;
        logic busy;
        logic done;
        logic timeout;
        logic meas_done;
    } t_step;

    typedef struct packed {
        logic                trigger_level;
        logic                busy_res;
        logic                done_res;
        logic [STATUS_W-1:0] status;
        logic [DIST_W-1:0]   distance_mm;
    } t_out_pay;

endpackage

>>> rtl/uer_in_if.sv
interface uer_in_if;
    logic valid;
    logic ready;
    logic start_req;
    logic echo_level;

    modport source (output valid, output start_req, output echo_level, input ready);
    modport sink   (input valid, input start_req, input echo_level, output ready);
endinterface

>>> rtl/uer_out_if.sv
interface uer_out_if;
    logic        valid;
    logic        ready;
    logic        trigger_level;
    logic        busy_res;
    logic        done_res;
    logic [1:0]  status;
    logic [26:0] distance_mm;

    modport source (output valid, output trigger_level, output busy_res, output done_res,
                    output status, output distance_mm, input ready);
    modport sink   (input valid, input trigger_level, input busy_res, input done_res,
                    input status, input distance_mm, output ready);
endinterface

>>> rtl/uer_cfg_regs.sv
module uer_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [uer_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [uer_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output uer_pkg::t_cfg                  o_cfg
);
    import uer_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trigger_ticks    <= RST_TRIGGER_TICKS;
            r_cfg.ticks_per_unit   <= RST_TICKS_PER_UNIT;
            r_cfg.timeout_count    <= RST_TIMEOUT_COUNT;
            r_cfg.mm_per_two_units <= RST_MM_PER_TWO_UNITS;
            r_cfg.min_mm           <= RST_MIN_MM;
            r_cfg.max_mm           <= RST_MAX_MM;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TRIGGER_TICKS:    r_cfg.trigger_ticks    <= i_cfg_data[15:0];
                CFG_TICKS_PER_UNIT:   r_cfg.ticks_per_unit   <= i_cfg_data[7:0];
                CFG_TIMEOUT_COUNT:    r_cfg.timeout_count    <= i_cfg_data[23:0];
                CFG_MM_PER_TWO_UNITS: r_cfg.mm_per_two_units <= i_cfg_data[3:0];
                CFG_MIN_MM:           r_cfg.min_mm           <= i_cfg_data[15:0];
                CFG_MAX_MM:           r_cfg.max_mm           <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> rtl/uer_ctrl.sv
module uer_ctrl #(
    parameter int COUNT_WIDTH = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  logic                   i_start,
    input  logic                   i_echo,
    input  uer_pkg::t_cfg          i_cfg,
    output uer_pkg::t_step         o_step,
    output logic [COUNT_WIDTH-1:0] o_units
);
    import uer_pkg::*;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_TRIG = 2'd1;
    localparam logic [1:0] PH_WAIT = 2'd2;
    localparam logic [1:0] PH_MEAS = 2'd3;

    localparam int CMP_W = (COUNT_WIDTH > 24) ? COUNT_WIDTH : 24;

    logic [1:0]             r_phase, n_phase;
    logic [15:0]            r_tick, n_tick;
    logic [COUNT_WIDTH-1:0] r_event_count, n_event_count;

    logic [15:0]            tick_inc;
    logic [COUNT_WIDTH-1:0] event_inc;
    logic                   expired;
    t_step                  step;

    assign tick_inc  = r_tick + 16'd1;
    assign event_inc = r_event_count + COUNT_WIDTH'(1);
    // A count pinned at the top of its range times out as well.
    assign expired   = (CMP_W'(r_event_count) >= CMP_W'(i_cfg.timeout_count))
                       || (&r_event_count);

    always_comb begin
        n_phase       = r_phase;
        n_tick        = r_tick;
        n_event_count = r_event_count;
        step          = '0;
        unique case (r_phase)
            PH_IDLE: begin
                if (i_start) begin
                    step.busy     = 1'b1;
                    n_phase       = PH_TRIG;
                    n_tick        = '0;
                    n_event_count = '0;
                end
            end
            PH_TRIG: begin
                step.busy = 1'b1;
                step.trig = 1'b1;
                n_tick    = tick_inc;
                if (tick_inc >= i_cfg.trigger_ticks) begin
                    n_phase       = PH_WAIT;
                    n_tick        = '0;
                    n_event_count = '0;
                end
            end
            PH_WAIT: begin
                step.busy = 1'b1;
                if (i_echo) begin
                    n_phase       = PH_MEAS;
                    n_tick        = '0;
                    n_event_count = '0;
                end else if (expired) begin
                    step.done    = 1'b1;
                    step.timeout = 1'b1;
                    n_phase      = PH_IDLE;
                end else begin
                    n_event_count = event_inc;
                end
            end
            PH_MEAS: begin
                step.busy = 1'b1;
                n_tick    = tick_inc;
                // The echo is only looked at when a unit completes.
                if (tick_inc >= {8'd0, i_cfg.ticks_per_unit}) begin
                    n_tick = '0;
                    if (expired) begin
                        step.done    = 1'b1;
                        step.timeout = 1'b1;
                        n_phase      = PH_IDLE;
                    end else begin
                        n_event_count = event_inc;
                        if (!i_echo) begin
                            step.done      = 1'b1;
                            step.meas_done = 1'b1;
                            n_phase        = PH_IDLE;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_tick        <= '0;
            r_event_count <= '0;
        end else if (i_accept) begin
            r_phase       <= n_phase;
            r_tick        <= n_tick;
            r_event_count <= n_event_count;
        end
    end

    assign o_step  = step;
    assign o_units = event_inc;

    a_start_enters_trigger: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && (r_phase == PH_IDLE) && i_start |=> r_phase == PH_TRIG)
        else $error("start beat in idle did not enter the trigger phase");

    a_hold_without_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_accept |=> $stable(r_phase) && $stable(r_tick) && $stable(r_event_count))
        else $error("sequencer state moved without an input beat");

    a_wait_counts_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && (r_phase == PH_WAIT) && !i_echo && !expired
        |=> (r_phase == PH_WAIT)
            && (r_event_count == $past(r_event_count) + COUNT_WIDTH'(1)))
        else $error("wait tick did not advance the count");

    a_done_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && step.done |=> r_phase == PH_IDLE)
        else $error("finished measurement did not return to idle");

endmodule

>>> rtl/uer_dist.sv
module uer_dist #(
    parameter int COUNT_WIDTH = 24
) (
    input  logic [COUNT_WIDTH-1:0]    i_units,
    input  uer_pkg::t_cfg             i_cfg,
    output logic [uer_pkg::DIST_W-1:0] o_dist,
    output logic                      o_out_of_range
);
    import uer_pkg::*;

    localparam int PROD_W = COUNT_WIDTH + 3;
    localparam int EXT_W  = (PROD_W > DIST_W) ? PROD_W : DIST_W;

    logic [PROD_W-1:0] prod;
    logic [EXT_W-1:0]  prod_ext;
    logic [DIST_W-1:0] dist_val;

    // Whole pairs of units times millimetres per pair.
    assign prod     = PROD_W'(i_units[COUNT_WIDTH-1:1]) * PROD_W'(i_cfg.mm_per_two_units);
    assign prod_ext = EXT_W'(prod);
    assign dist_val = (prod_ext > EXT_W'(DIST_MAX)) ? DIST_MAX : prod_ext[DIST_W-1:0];

    assign o_dist         = dist_val;
    assign o_out_of_range = (dist_val == '0)
                            || (dist_val < DIST_W'(i_cfg.min_mm))
                            || (dist_val > DIST_W'(i_cfg.max_mm));

endmodule

>>> rtl/ultrasonic_echo_ranger_core.sv
// Ultrasonic echo ranger, stepped once per microsecond tick.
// Each input beat on i_in_ch carries one tick: a start request and the
// sampled echo pin level. Each input beat yields exactly one output beat on
// o_out_ch with the trigger pin level, busy and done flags, status and
// distance for that tick.
// The result of a beat is registered and shows on o_out_ch in the next cycle.
// Throughput is one beat per cycle while the receiver takes each output beat;
// the phase sequencer, the distance multiply and the range compare all settle
// within that cycle between the state registers and the output register.
// When the receiver stalls, the output register holds its beat and one more
// input beat is taken only as the held beat leaves, so i_in_ch.ready drops
// while the output is full and not taken.
// Reset (synchronous, active low) returns the sequencer to idle, clears the
// counters, empties the output register and loads the default settings.
// Settings must be written through i_cfg_we / i_cfg_idx / i_cfg_data while the
// block is idle; the block does not enforce this. Indexes past the last register are ignored.
module ultrasonic_echo_ranger_core #(
    parameter int COUNT_WIDTH = 24
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    uer_in_if.sink                         i_in_ch,
    uer_out_if.source                      o_out_ch,
    input  logic                           i_cfg_we,
    input  logic [uer_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [uer_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import uer_pkg::*;

    t_cfg                   cfg;
    t_step                  step;
    logic [COUNT_WIDTH-1:0] units;
    logic [DIST_W-1:0]      dist_mm;
    logic                   out_of_range;
    logic                   in_ready;
    logic                   accept;

    logic                   r_out_valid, n_out_valid;
    t_out_pay               r_out, n_out;

    uer_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    uer_ctrl #(.COUNT_WIDTH(COUNT_WIDTH)) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_start  (i_in_ch.start_req),
        .i_echo   (i_in_ch.echo_level),
        .i_cfg    (cfg),
        .o_step   (step),
        .o_units  (units)
    );

    uer_dist #(.COUNT_WIDTH(COUNT_WIDTH)) u_dist (
        .i_units        (units),
        .i_cfg          (cfg),
        .o_dist         (dist_mm),
        .o_out_of_range (out_of_range)
    );

    assign in_ready = !r_out_valid || o_out_ch.ready;
    assign accept   = i_in_ch.valid && in_ready;

    always_comb begin
        n_out.trigger_level = step.trig;
        n_out.busy_res      = step.busy;
        n_out.done_res      = step.done;
        n_out.status        = ST_VALID;
        n_out.distance_mm   = '0;
        if (step.timeout) begin
            n_out.status = ST_TIMEOUT;
        end else if (step.meas_done) begin
            n_out.status      = out_of_range ? ST_RANGE : ST_VALID;
            n_out.distance_mm = dist_mm;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (accept) begin
            n_out_valid = 1'b1;
        end else if (o_out_ch.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    assign i_in_ch.ready          = in_ready;
    assign o_out_ch.valid         = r_out_valid;
    assign o_out_ch.trigger_level = r_out.trigger_level;
    assign o_out_ch.busy_res      = r_out.busy_res;
    assign o_out_ch.done_res      = r_out.done_res;
    assign o_out_ch.status        = r_out.status;
    assign o_out_ch.distance_mm   = r_out.distance_mm;

endmodule
